/* design/integer_to_ascii_formatter_macros.svh */
// assertion macros for the integer to ascii formatter
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define I2A_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define I2A_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define I2A_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define I2A_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* design/i2a_pkg.sv */
package i2a_pkg;

   // format commands
   localparam logic [1:0] CMD_SDEC = 2'd0;
   localparam logic [1:0] CMD_UDEC = 2'd1;
   localparam logic [1:0] CMD_LHEX = 2'd2;
   localparam logic [1:0] CMD_UHEX = 2'd3;

   localparam int I2A_MAX_DIGITS = 10;
   localparam int I2A_CNT_W      = 4;
   localparam int I2A_QUOT_W     = 29;

   // floor(n * I2A_RECIP10 / 2**35) == n / 10 for every 32-bit n
   localparam logic [31:0] I2A_RECIP10 = 32'hCCCC_CCCD;
   localparam int          I2A_RECIP_SHIFT = 35;

   localparam logic [7:0] ASC_ZERO  = 8'h30;
   localparam logic [7:0] ASC_MINUS = 8'h2D;
   localparam logic [7:0] ASC_LOW_A = 8'h61;
   localparam logic [7:0] ASC_UP_A  = 8'h41;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIG,
      ST_HEX,
      ST_EMIT
   } state_type;

   function automatic logic [7:0] i2a_ascii(input logic [3:0] nib, input logic upper);
      logic [7:0] base;
      if (nib < 4'd10) begin
         i2a_ascii = ASC_ZERO + {4'b0, nib};
      end else begin
         base = upper ? ASC_UP_A : ASC_LOW_A;
         i2a_ascii = base + {4'b0, nib} - 8'd10;
      end
   endfunction

endpackage

/* design/integer_to_ascii_formatter.sv */
// each decimal digit takes a multiply on the 32x32 reciprocal multiplier
// (ST_MUL), then a digit extract (ST_DIG); each hex digit takes ST_HEX alone;
// characters then leave one per cycle through the output register while rsp_tready allows.
// req_tready is low from acceptance until the last character is loaded.
// reset (synchronous, active high) clears the sequencer and the output valid.
`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter
   import i2a_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // character[7:0]
   output logic        rsp_tlast
);

   state_type state_ff, state_in;
   logic [31:0] mag_ff, mag_in;
   logic [63:0] prod_ff, prod_in;
   logic [I2A_CNT_W-1:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in;
   logic upper_ff, upper_in;
   logic [3:0] digits_ff [I2A_MAX_DIGITS];
   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0] rsp_tdata_ff, rsp_tdata_in;
   logic rsp_tlast_ff, rsp_tlast_in;

   logic push_en;
   logic [3:0] push_val;
   logic out_free;
   logic [I2A_QUOT_W-1:0] quot;
   logic [3:0] q10_lo;
   logic [I2A_CNT_W-1:0] top_idx;
   logic is_neg;
   logic pop_last;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign quot     = prod_ff[63:I2A_RECIP_SHIFT];
   // only the low nibble of quot*10 matters, the remainder is below ten
   assign q10_lo   = 4'({quot[2:0], 1'b0} + {quot[0], 3'b0});
   assign top_idx  = cnt_ff - I2A_CNT_W'(1);
   assign is_neg   = (req_tuser == CMD_SDEC) && req_tdata[31];
   assign pop_last = (cnt_ff == I2A_CNT_W'(1)) && !neg_ff;

   always_comb begin
      state_in      = state_ff;
      mag_in        = mag_ff;
      prod_in       = prod_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      upper_in      = upper_ff;
      push_en       = 1'b0;
      push_val      = 4'd0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      req_tready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               neg_in   = is_neg;
               upper_in = (req_tuser == CMD_UHEX);
               mag_in   = is_neg ? 32'(32'd0 - req_tdata) : req_tdata;
               cnt_in   = '0;
               state_in = (req_tuser == CMD_LHEX || req_tuser == CMD_UHEX) ? ST_HEX : ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = 64'(mag_ff) * 64'(I2A_RECIP10);
            state_in = ST_DIG;
         end
         ST_DIG: begin
            push_en  = 1'b1;
            push_val = mag_ff[3:0] - q10_lo;
            mag_in   = 32'(quot);
            cnt_in   = cnt_ff + I2A_CNT_W'(1);
            state_in = (quot == '0) ? ST_EMIT : ST_MUL;
         end
         ST_HEX: begin
            push_en  = 1'b1;
            push_val = mag_ff[3:0];
            mag_in   = {4'd0, mag_ff[31:4]};
            cnt_in   = cnt_ff + I2A_CNT_W'(1);
            state_in = (mag_ff[31:4] == '0) ? ST_EMIT : ST_HEX;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               if (neg_ff) begin
                  rsp_tdata_in = ASC_MINUS;
                  rsp_tlast_in = 1'b0;
                  neg_in       = 1'b0;
               end else begin
                  rsp_tdata_in = i2a_ascii(digits_ff[top_idx], upper_ff);
                  rsp_tlast_in = pop_last;
                  cnt_in       = top_idx;
                  if (pop_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         neg_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         neg_ff        <= neg_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      prod_ff      <= prod_in;
      upper_ff     <= upper_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
      if (push_en) begin
         digits_ff[cnt_ff] <= push_val;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `I2A_ASSERT_IMP(a_stack_bound, clock, reset,
      (state_ff == ST_DIG || state_ff == ST_HEX), (cnt_ff < I2A_CNT_W'(I2A_MAX_DIGITS)))
   `I2A_ASSERT_IMP(a_emit_nonempty, clock, reset, (state_ff == ST_EMIT), (cnt_ff != '0))
   `I2A_ASSERT_NXT(a_last_loaded, clock, reset,
      (state_ff == ST_EMIT && out_free && pop_last), (rsp_tvalid_ff && rsp_tlast_ff))
   `I2A_ASSERT_IMP(a_sign_dec_only, clock, reset,
      (neg_ff && state_ff != ST_IDLE), (state_ff != ST_HEX && !upper_ff))

endmodule
